// ----- src/cai_pkg.sv -----
// Shared types and codes for the checked 64-bit integer ALU.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cai_pkg;

   localparam int unsigned DATA_W  = 64;
   localparam int unsigned DIV_LEN = DATA_W;

   // operation codes
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_REM = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DOM   = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [DATA_W-1:0] MOST_NEG  = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] MOST_POS  = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MINUS_ONE = {DATA_W{1'b1}};

   // what the tail of the chain does with a beat
   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_DIV,
      KIND_REM
   } kind_type;

   // one beat as it travels down the divider chain
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic              neg_q;
      logic              neg_r;
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] quo;
      logic [DATA_W-1:0] dvs;
      logic [DATA_W-1:0] res;
      logic [1:0]        status;
   } cell_type;

endpackage

// ----- src/checked_int64_alu_top.sv -----
// Top level of the checked 64-bit integer ALU: front end, divider chain, output register.
// Depends on cai_pkg, cai_front and cai_div_cell.
`timescale 1ns / 1ps

// A request is taken on every cycle that start is high; busy is always low.
// Every request gives one response beat after passing 3 front-end stages,
// 64 division cells and 1 output register, marked by rsp_strobe for one
// cycle, in request order. The receiver cannot stall; the strobe must be taken
// when it appears. Add, subtract and multiply report exact overflow; divide
// and remainder truncate toward zero. On any error the result is operand_a.
module checked_int64_alu_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_type,
   input  logic signed [63:0]         req_operand_a,
   input  logic signed [63:0]         req_operand_b,
   output logic                       rsp_strobe,
   output logic signed [63:0]         rsp_result,
   output logic [1:0]                 rsp_status
);
   import cai_pkg::*;

   cell_type          link [0:DIV_LEN];
   cell_type          last;
   logic              strobe_ff;
   logic [DATA_W-1:0] result_ff, result_in;
   logic [1:0]        status_ff;

   assign busy = 1'b0;

   cai_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_op    (req_type),
      .in_a     (req_operand_a),
      .in_b     (req_operand_b),
      .out_cell (link[0])
   );

   // row of division cells, one quotient bit each
   for (genvar i = 0; i < DIV_LEN; i++) begin : g_cell
      cai_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_cell  (link[i]),
         .out_cell (link[i+1])
      );
   end

   assign last = link[DIV_LEN];

   // sign fixup of quotient or remainder; other beats pass the front-end result
   always_comb begin
      case (last.kind)
         KIND_DIV: result_in = last.neg_q ? (DATA_W'(0) - last.quo) : last.quo;
         KIND_REM: result_in = last.neg_r ? (DATA_W'(0) - last.rem) : last.rem;
         default:  result_in = last.res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= last.valid;
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      status_ff <= last.status;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_result = result_ff;
   assign rsp_status = status_ff;

endmodule

// ----- src/cai_front.sv -----
// Front end: operand capture, 64x64 multiply from 32x32-bit partial products,
// add/sub overflow checks and divide special cases. Depends on cai_pkg.
`timescale 1ns / 1ps

module cai_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [2:0]                   in_op,
   input  logic [cai_pkg::DATA_W-1:0]   in_a,
   input  logic [cai_pkg::DATA_W-1:0]   in_b,
   output cai_pkg::cell_type            out_cell
);
   import cai_pkg::*;

   localparam int unsigned HALF = DATA_W / 2;

   // stage 1: captured request with magnitudes
   logic              v1_ff;
   logic [2:0]        op1_ff;
   logic [DATA_W-1:0] a1_ff, b1_ff, ua1_ff, ub1_ff;
   // stage 2: partial products
   logic              v2_ff;
   logic [2:0]        op2_ff;
   logic [DATA_W-1:0] a2_ff, b2_ff, ua2_ff, ub2_ff;
   logic [DATA_W-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   // stage 3: beat entering the chain
   cell_type          cell_ff, cell_in;

   logic [DATA_W-1:0] ua_in, ub_in;
   logic [HALF+2:0]   mid;
   logic [DATA_W-1:0] lo, hi, sum, dif, prod_neg;
   logic              neg_m, mul_ovf, add_ovf, sub_ovf;

   assign ua_in = in_a[DATA_W-1] ? (DATA_W'(0) - in_a) : in_a;
   assign ub_in = in_b[DATA_W-1] ? (DATA_W'(0) - in_b) : in_b;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         cell_ff.valid <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         cell_ff.valid <= cell_in.valid;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op1_ff <= in_op;
      a1_ff  <= in_a;
      b1_ff  <= in_b;
      ua1_ff <= ua_in;
      ub1_ff <= ub_in;

      op2_ff <= op1_ff;
      a2_ff  <= a1_ff;
      b2_ff  <= b1_ff;
      ua2_ff <= ua1_ff;
      ub2_ff <= ub1_ff;
      p00_ff <= DATA_W'(ua1_ff[HALF-1:0])      * DATA_W'(ub1_ff[HALF-1:0]);
      p01_ff <= DATA_W'(ua1_ff[HALF-1:0])      * DATA_W'(ub1_ff[DATA_W-1:HALF]);
      p10_ff <= DATA_W'(ua1_ff[DATA_W-1:HALF]) * DATA_W'(ub1_ff[HALF-1:0]);
      p11_ff <= DATA_W'(ua1_ff[DATA_W-1:HALF]) * DATA_W'(ub1_ff[DATA_W-1:HALF]);

      cell_ff.kind   <= cell_in.kind;
      cell_ff.neg_q  <= cell_in.neg_q;
      cell_ff.neg_r  <= cell_in.neg_r;
      cell_ff.rem    <= cell_in.rem;
      cell_ff.quo    <= cell_in.quo;
      cell_ff.dvs    <= cell_in.dvs;
      cell_ff.res    <= cell_in.res;
      cell_ff.status <= cell_in.status;
   end

   // combine partial products and check ranges
   always_comb begin
      mid = (HALF+3)'(p00_ff[DATA_W-1:HALF]) + (HALF+3)'(p01_ff[HALF-1:0])
          + (HALF+3)'(p10_ff[HALF-1:0]);
      lo  = {mid[HALF-1:0], p00_ff[HALF-1:0]};
      hi  = p11_ff + DATA_W'(p01_ff[DATA_W-1:HALF]) + DATA_W'(p10_ff[DATA_W-1:HALF])
          + DATA_W'(mid[HALF+2:HALF]);
      neg_m    = a2_ff[DATA_W-1] ^ b2_ff[DATA_W-1];
      mul_ovf  = (hi != '0) || (!neg_m && lo > MOST_POS) || (neg_m && lo > MOST_NEG);
      prod_neg = neg_m ? (DATA_W'(0) - lo) : lo;
      sum      = a2_ff + b2_ff;
      dif      = a2_ff - b2_ff;
      add_ovf  = ((a2_ff ^ sum) & (b2_ff ^ sum)) >> (DATA_W-1) != '0;
      sub_ovf  = ((a2_ff ^ b2_ff) & (a2_ff ^ dif)) >> (DATA_W-1) != '0;

      cell_in.valid  = v2_ff;
      cell_in.kind   = KIND_PASS;
      cell_in.neg_q  = neg_m;
      cell_in.neg_r  = a2_ff[DATA_W-1];
      cell_in.rem    = '0;
      cell_in.quo    = ua2_ff;
      cell_in.dvs    = ub2_ff;
      cell_in.res    = a2_ff;
      cell_in.status = ST_OK;

      case (op2_ff) inside
         OP_ADD: begin
            if (add_ovf) cell_in.status = ST_RANGE;
            else cell_in.res = sum;
         end
         OP_SUB: begin
            if (sub_ovf) cell_in.status = ST_RANGE;
            else cell_in.res = dif;
         end
         OP_MUL: begin
            if (mul_ovf) cell_in.status = ST_RANGE;
            else cell_in.res = prod_neg;
         end
         OP_DIV, OP_REM: begin
            if (b2_ff == '0) begin
               cell_in.status = ST_DOM;
            end else if (a2_ff == MOST_NEG && b2_ff == MINUS_ONE) begin
               cell_in.status = ST_RANGE;
            end else begin
               cell_in.kind = (op2_ff == OP_DIV) ? KIND_DIV : KIND_REM;
            end
         end
         default: ;  // unused codes leave operand_a untouched
      endcase
   end

   assign out_cell = cell_ff;

endmodule

// ----- src/cai_div_cell.sv -----
// One restoring-division step: shifts one dividend bit into the partial
// remainder and emits one quotient bit, then registers the beat. Depends on cai_pkg.
`timescale 1ns / 1ps

module cai_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  cai_pkg::cell_type in_cell,
   output cai_pkg::cell_type out_cell
);
   import cai_pkg::*;

   cell_type          cell_ff, cell_in;
   logic [DATA_W:0]   shifted, diff;
   logic              fits;

   // trial subtract
   always_comb begin
      shifted = {in_cell.rem, in_cell.quo[DATA_W-1]};
      diff    = shifted - {1'b0, in_cell.dvs};
      fits    = !diff[DATA_W];
      cell_in     = in_cell;
      cell_in.rem = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      cell_in.quo = {in_cell.quo[DATA_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) cell_ff.valid <= 1'b0;
      else cell_ff.valid <= cell_in.valid;
   end

   always_ff @(posedge clock) begin
      cell_ff.kind   <= cell_in.kind;
      cell_ff.neg_q  <= cell_in.neg_q;
      cell_ff.neg_r  <= cell_in.neg_r;
      cell_ff.rem    <= cell_in.rem;
      cell_ff.quo    <= cell_in.quo;
      cell_ff.dvs    <= cell_in.dvs;
      cell_ff.res    <= cell_in.res;
      cell_ff.status <= cell_in.status;
   end

   assign out_cell = cell_ff;

endmodule
